/* hdl/nns_pkg.sv */
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants for the nearest neighbour search block.
// ----------------------------------------------------------------------------
package nns_pkg;

  localparam int MaxLength = 128;
  localparam int AddrW = $clog2(MaxLength);
  localparam int LenW = 8;
  localparam int IdxW = 16;
  localparam int DistW = 43;
  localparam int SqW = 43;
  localparam int DotW = 40;
  localparam int NormW = 39;
  localparam int PW = 2 * NormW;
  localparam int NumW = PW + 31;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [DistW-1:0] DistMax = DistW'(64'd1 << 42);

  typedef enum logic {
    OpQuery     = 1'b0,
    OpCandidate = 1'b1
  } op_e;

  typedef enum logic {
    RegMetric = 1'b0,
    RegLength = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkMul,
    BkDiv,
    BkDone
  } bk_state_e;

  typedef struct packed {
    logic             metric;
    logic             last;
    logic [SqW-1:0]   sq;
    logic [DotW-1:0]  dot;
    logic [NormW-1:0] qn;
    logic [NormW-1:0] cn;
  } cand_t;

endpackage

/* hdl/nearest_neighbour_search.sv */
// ----------------------------------------------------------------------------
// nearest_neighbour_search
// Exhaustive nearest neighbour search over streamed candidate vectors.
// ----------------------------------------------------------------------------
// Elements are taken at one per cycle; the front end stalls only when the
// queue is full. It stores query elements and accumulates candidate sums;
// each finished candidate enters a 4-deep queue. The back end takes a
// euclidean candidate straight to done and a cosine one through the
// multiply state, then one quotient bit per cycle for 42 bits; a zero norm
// skips the multiply and an early result the division. While a result
// waits for the receiver the back end holds, so the queue fills. Input thus
// runs at full rate while vectors are long against the back end time.
module nearest_neighbour_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // element_value
  input  logic        s_axis_tlast,  // last_candidate
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // best_index, best_distance, zero_norm_seen
  output logic        m_axis_tlast
);
  import nns_pkg::*;

  logic metric_q;
  logic [7:0] len_q;
  logic push, full, pop, empty;
  cand_t cin, cout;
  logic [15:0] bi;
  logic [DistW-1:0] bd;
  logic zn;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0; len_q <= 8'd128;
    end else if (cfg_valid_i) begin
      if (reg_e'(cfg_index_i) == RegMetric) metric_q <= cfg_data_i[0];
      else len_q <= cfg_data_i;
    end
  end

  nns_front u_front (
    .clk_i, .rst_ni, .metric_i(metric_q), .vector_length_i(len_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tuser), .elem_i(s_axis_tdata), .last_i(s_axis_tlast),
    .push_o(push), .cand_o(cin), .q_full_i(full)
  );

  nns_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cin), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(cout)
  );

  nns_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cand_i(cout), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .best_index_o(bi), .best_distance_o(bd), .zero_norm_o(zn)
  );

  assign m_axis_tdata = {4'd0, zn, bd, bi};
  assign m_axis_tlast = 1'b1;
endmodule

/* hdl/nns_front.sv */
// ----------------------------------------------------------------------------
// nns_front
// Element front end: query store, per-candidate accumulation, hands sums of
// each finished candidate to the back end queue.
// ----------------------------------------------------------------------------
module nns_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   metric_i,
  input  logic [7:0]             vector_length_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic signed [15:0]     elem_i,
  input  logic                   last_i,
  output logic                   push_o,
  output nns_pkg::cand_t         cand_o,
  input  logic                   q_full_i
);
  import nns_pkg::*;

  logic [15:0] store_q [MaxLength];
  logic [15:0] qrd_q;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [SqW-1:0] sq_q, sq_d;
  logic signed [DotW-1:0] dot_q, dot_d;
  logic [NormW-1:0] qn_q, qn_d, cn_q, cn_d;
  logic [LenW-1:0] len;
  logic ends, acc;
  logic signed [15:0] qv;
  logic signed [16:0] df;
  logic [AddrW-1:0] pos, npos;

  always_comb begin
    if (vector_length_i == '0) len = LenW'(1);
    else if (32'(vector_length_i) > MaxLength) len = LenW'(MaxLength);
    else len = vector_length_i;
  end

  assign pos = cnt_q[AddrW-1:0];
  assign npos = cnt_d[AddrW-1:0];
  assign ends = (9'(cnt_q) + 9'd1) >= 9'(len);
  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;
  assign qv = signed'(qrd_q);
  assign df = 17'(elem_i) - 17'(qv);

  // registered read of the entry for the next element, new data on a hit
  always_ff @(posedge clk_i) begin
    if (acc && op_e'(op_i) == OpQuery) store_q[pos] <= elem_i;
    if (acc && op_e'(op_i) == OpQuery && npos == pos) qrd_q <= elem_i;
    else qrd_q <= store_q[npos];
  end

  always_comb begin
    cnt_d = cnt_q;
    sq_d = sq_q;
    dot_d = dot_q;
    qn_d = qn_q;
    cn_d = cn_q;
    push_o = 1'b0;
    cand_o.metric = metric_i;
    cand_o.last = last_i;
    cand_o.sq = SqW'(sq_q + SqW'(34'(df * df)));
    cand_o.dot = DotW'(dot_q + DotW'(32'(qv) * 32'(elem_i)));
    cand_o.qn = NormW'(qn_q + NormW'(32'(qv * qv)));
    cand_o.cn = NormW'(cn_q + NormW'(32'(elem_i * elem_i)));
    if (acc) begin
      cnt_d = ends ? '0 : LenW'(cnt_q + 1'b1);
      if (op_e'(op_i) == OpQuery) begin
        sq_d = '0; dot_d = '0; qn_d = '0; cn_d = '0;
      end else if (ends) begin
        push_o = 1'b1;
        sq_d = '0; dot_d = '0; qn_d = '0; cn_d = '0;
      end else begin
        sq_d = cand_o.sq;
        dot_d = cand_o.dot;
        qn_d = cand_o.qn;
        cn_d = cand_o.cn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sq_q <= '0; dot_q <= '0; qn_q <= '0; cn_q <= '0;
    end else begin
      cnt_q <= cnt_d; sq_q <= sq_d; dot_q <= dot_d; qn_q <= qn_d; cn_q <= cn_d;
    end
  end
endmodule

/* hdl/nns_queue.sv */
// ----------------------------------------------------------------------------
// nns_queue
// Small FIFO of finished candidate sums between front and back end.
// ----------------------------------------------------------------------------
module nns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nns_pkg::cand_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output nns_pkg::cand_t data_o
);
  import nns_pkg::*;

  cand_t mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0] n_q;

  assign full_o = n_q == (QPtrW+1)'(QDepth);
  assign empty_o = n_q == '0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; n_q <= '0;
    end else begin
      if (push_i) wp_q <= QPtrW'(wp_q + 1'b1);
      if (pop_i) rp_q <= QPtrW'(rp_q + 1'b1);
      n_q <= (QPtrW+1)'(n_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i));
    end
  end
endmodule

/* hdl/nns_mul.sv */
// ----------------------------------------------------------------------------
// nns_mul
// 39x39 unsigned multiplier that sums four partial products in turn.
// ----------------------------------------------------------------------------
module nns_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nns_pkg::NormW-1:0] a_i,
  input  logic [nns_pkg::NormW-1:0] b_i,
  output logic                      done_o,
  output logic [nns_pkg::PW-1:0]    p_o
);
  import nns_pkg::*;

  localparam int HW = 20;
  logic [2:0] st_q;
  logic [PW-1:0] acc_q;
  logic [HW-1:0] ah, bh;
  logic [2*HW-1:0] pp;
  logic [6:0] sh;

  always_comb begin
    ah = st_q[1] ? HW'(a_i >> HW) : a_i[HW-1:0];
    bh = st_q[0] ? HW'(b_i >> HW) : b_i[HW-1:0];
    sh = 7'((32'(st_q[1]) + 32'(st_q[0])) * HW);
  end
  assign pp = ah * bh;
  assign p_o = acc_q;
  assign done_o = st_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= 3'd4; acc_q <= '0;
    end else if (start_i) begin
      st_q <= '0; acc_q <= '0;
    end else if (!st_q[2]) begin
      acc_q <= PW'(acc_q + (PW'(pp) << sh));
      st_q <= 3'(st_q + 1'b1);
    end
  end
endmodule

/* hdl/nns_back.sv */
// ----------------------------------------------------------------------------
// nns_back
// Distance evaluation, best tracking and result register.
// ----------------------------------------------------------------------------
module nns_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  nns_pkg::cand_t              cand_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 best_index_o,
  output logic [nns_pkg::DistW-1:0]   best_distance_o,
  output logic                        zero_norm_o
);
  import nns_pkg::*;

  bk_state_e st_q, st_d;
  logic mstart, mdone;
  logic [PW-1:0] p;
  logic [NumW-1:0] n_q, n_d;
  logic [5:0] b_q, b_d;
  logic [DistW-1:0] res_q, res_d, cand_dist;
  logic dist_ok;
  logic [IdxW-1:0] cand_q, best_pos_q;
  logic [DistW-1:0] best_q;
  logic best_v_q, zf_q;
  logic ov_q;
  logic [PW:0] mag, dsh;
  logic [PW+1:0] num;
  logic zero_n, early0, early_max;
  logic [PW+42:0] qsh, nsub;

  nns_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(cand_i.qn), .b_i(cand_i.cn),
    .done_o(mdone), .p_o(p)
  );

  assign zero_n = cand_i.qn == '0 || cand_i.cn == '0;
  assign mag = cand_i.dot[DotW-1] ? (PW+1)'(DotW'(-cand_i.dot)) : (PW+1)'(cand_i.dot);
  assign dsh = (PW+1)'(mag << 16);
  assign early0 = !cand_i.dot[DotW-1] && dsh >= (PW+1)'(p);
  assign num = cand_i.dot[DotW-1] ? (PW+2)'(p) + (PW+2)'(dsh)
                                  : (PW+2)'(p) - (PW+2)'(dsh);
  assign early_max = (PW+13)'(num) >= ((PW+13)'(p) << 12);
  assign qsh = (PW+43)'(p) << b_q;
  assign nsub = (PW+43)'(n_q) - qsh;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle: if (!empty_i && !ov_q) begin
        if (!cand_i.metric || zero_n) st_d = BkDone;
        else st_d = BkMul;
      end
      BkMul: if (mdone) begin
        if (early0 || early_max) st_d = BkDone;
        else st_d = BkDiv;
      end
      BkDiv: if (b_q == '0) st_d = BkDone;
      BkDone: st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_comb begin
    mstart = st_q == BkIdle && !empty_i && !ov_q;
    n_d = n_q; b_d = b_q; res_d = res_q;
    dist_ok = 1'b0;
    cand_dist = res_q;
    pop_o = 1'b0;
    unique case (st_q)
      BkIdle: begin
        res_d = !cand_i.metric ? cand_i.sq : DistMax;
      end
      BkMul: if (mdone) begin
        n_d = NumW'(num) << 30; b_d = 6'd41; res_d = '0;
        if (early0) res_d = '0;
        else if (early_max) res_d = DistMax;
      end
      BkDiv: begin
        if (!nsub[PW+42]) begin
          n_d = nsub[NumW-1:0];
          res_d = res_q | (DistW'(1) << b_q);
        end
        b_d = 6'(b_q - 1'b1);
      end
      BkDone: begin
        dist_ok = 1'b1; pop_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; b_q <= b_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; cand_q <= '0; best_pos_q <= '0; best_q <= '0;
      best_v_q <= 1'b0; zf_q <= 1'b0; ov_q <= 1'b0;
      best_index_o <= '0; best_distance_o <= '0; zero_norm_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (dist_ok) begin
        logic take, zfn;
        logic [DistW-1:0] bd;
        logic [IdxW-1:0] bp;
        take = !best_v_q || cand_dist < best_q;
        bd = take ? cand_dist : best_q;
        bp = take ? cand_q : best_pos_q;
        zfn = zf_q || (cand_i.metric && zero_n);
        if (cand_i.last) begin
          ov_q <= 1'b1;
          best_index_o <= bp; best_distance_o <= bd; zero_norm_o <= zfn;
          cand_q <= '0; best_q <= '0; best_pos_q <= '0;
          best_v_q <= 1'b0; zf_q <= 1'b0;
        end else begin
          cand_q <= IdxW'(cand_q + 1'b1);
          best_q <= bd; best_pos_q <= bp; best_v_q <= 1'b1; zf_q <= zfn;
        end
      end
    end
  end

  assign out_valid_o = ov_q;
endmodule

/* sim/nearest_neighbour_search_test.sv */
// ----------------------------------------------------------------------------
// nearest_neighbour_search_test
// Self-checking bench for the nearest neighbour search block.
// ----------------------------------------------------------------------------
// Directed rows cover extreme elements, both metrics, zero norms and query
// reloads inside a candidate. Random searches then run under several metric
// and length settings. The sender and receiver idle at random, and the
// receiver holds off once for a long stretch. Every result is compared with
// a behavioral model of the search or a value set in a directed row.
module nearest_neighbour_search_test;
  import nns_pkg::*;

  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] dist_val;
    logic             zn;
  } nn_result_t;

  typedef struct {
    bit          is_cfg;
    reg_e        reg_sel;
    logic [7:0]  cfg_val;
    op_e         op;
    logic [15:0] val;
    bit          last;
    bit          typed;
    nn_result_t  res;
  } row_t;

  localparam int Limit = 3000000;
  localparam int Drain = 400;
  localparam int HoldCycles = 3000;
  localparam int PressurePhase = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  nearest_neighbour_search u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // model state
  logic [15:0]     query_mem [MaxLength];
  bit              query_written [MaxLength];
  int unsigned     elem_cnt;
  int unsigned     cand_cnt;
  longint unsigned sq_sum;
  longint          dot_acc;
  longint unsigned qn_sum;
  longint unsigned cn_sum;
  logic [DistW-1:0] best_dist;
  int unsigned     best_pos;
  bit              best_ok;
  bit              zero_seen;
  bit              metric_r;
  int unsigned     length_r;

  nn_result_t nearest_q[$];
  bit         ovr_en;
  nn_result_t ovr_res;

  int  errors;
  int  n_items;
  int  n_results;
  int  n_cfg;
  int  cycles = 0;
  int  phase;
  int  snd_idle;
  int  rcv_idle;
  int  held;
  bit  search_open;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned active_len();
    if (length_r < 1) return 1;
    if (length_r > MaxLength) return MaxLength;
    return length_r;
  endfunction

  task automatic clear_sums();
    sq_sum = 0;
    dot_acc = 0;
    qn_sum = 0;
    cn_sum = 0;
  endtask

  function automatic logic [DistW-1:0] cosine_dist();
    logic [127:0] p;
    logic [127:0] d;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  mag;
    p = 128'(qn_sum) * 128'(cn_sum);
    mag = dot_acc < 0 ? 64'(-dot_acc) : 64'(dot_acc);
    d = 128'(mag) << 16;
    if (dot_acc >= 0) begin
      if (d >= p) return '0;
      num = p - d;
    end else begin
      num = p + d;
    end
    if (num >= (p << 12)) return DistMax;
    quo = (num << 30) / p;
    return quo[DistW-1:0];
  endfunction

  task automatic predict_search(input op_e op, input logic [15:0] v, input bit last,
                                output bit has, output nn_result_t r,
                                output bit cand_end);
    int unsigned len;
    int unsigned pos;
    bit ends;
    longint qv;
    longint cv;
    longint df;
    logic [DistW-1:0] cand_dist;
    len = active_len();
    pos = elem_cnt % MaxLength;
    ends = (elem_cnt + 1 >= len);
    has = 1'b0;
    cand_end = 1'b0;
    r = '{default: '0};
    if (op == OpQuery) begin
      clear_sums();
      query_mem[pos] = v;
      query_written[pos] = 1'b1;
      elem_cnt = ends ? 0 : elem_cnt + 1;
      return;
    end
    qv = longint'($signed(query_mem[pos]));
    cv = longint'($signed(v));
    df = cv - qv;
    sq_sum += longint'(df * df);
    dot_acc += qv * cv;
    qn_sum += longint'(qv * qv);
    cn_sum += longint'(cv * cv);
    if (!ends) begin
      elem_cnt++;
      return;
    end
    elem_cnt = 0;
    cand_end = 1'b1;
    if (metric_r) begin
      if (qn_sum == 0 || cn_sum == 0) begin
        zero_seen = 1'b1;
        cand_dist = DistMax;
      end else begin
        cand_dist = cosine_dist();
      end
    end else begin
      cand_dist = sq_sum[DistW-1:0];
    end
    clear_sums();
    if (!best_ok || cand_dist < best_dist) begin
      best_dist = cand_dist;
      best_pos = cand_cnt;
      best_ok = 1'b1;
    end
    cand_cnt = (cand_cnt + 1) % 65536;
    if (!last) return;
    r.idx = best_pos[IdxW-1:0];
    r.dist_val = best_dist;
    r.zn = zero_seen;
    has = 1'b1;
    cand_cnt = 0;
    best_dist = '0;
    best_pos = 0;
    best_ok = 1'b0;
    zero_seen = 1'b0;
  endtask

  task automatic send(input op_e op, input logic [15:0] v, input bit last,
                      output bit cand_end);
    int gap;
    bit has;
    nn_result_t r;
    gap = 0;
    while ($urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= v;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    predict_search(op, v, last, has, r, cand_end);
    if (has) nearest_q.insert(nearest_q.size(), ovr_en ? ovr_res : r);
  endtask

  task automatic write_reg(input reg_e sel, input logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    if (sel == RegMetric) metric_r = val[0];
    else length_r = val;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      held <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          nn_result_t e;
          e = nearest_q.pop_front();
          n_results++;
          if (m_axis_tdata[15:0] !== e.idx) begin
            $display("%0t: best_index exp %0d got %0d", $time, e.idx, m_axis_tdata[15:0]);
            errors++;
          end
          if (m_axis_tdata[58:16] !== e.dist_val) begin
            $display("%0t: best_distance exp %0d got %0d", $time, e.dist_val,
                     m_axis_tdata[58:16]);
            errors++;
          end
          if (m_axis_tdata[59] !== e.zn) begin
            $display("%0t: zero_norm_seen exp %0d got %0d", $time, e.zn, m_axis_tdata[59]);
            errors++;
          end
        end
      end
      if (phase == PressurePhase && held < HoldCycles) begin
        held <= held + 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  row_t rows[$];
  int   cfg_metric [9] = '{0, 1, 0, 1, 1, 0, 1, 0, 1};
  int   cfg_length [9] = '{4, 3, 0, 255, 1, 128, 7, 2, 16};

  function automatic row_t blank_row();
    row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = RegMetric;
    r.cfg_val = '0;
    r.op = OpQuery;
    r.val = '0;
    r.last = 1'b0;
    r.typed = 1'b0;
    r.res = '{default: '0};
    return r;
  endfunction

  function automatic row_t item(op_e op, logic [15:0] v, bit last);
    row_t r;
    r = blank_row();
    r.op = op;
    r.val = v;
    r.last = last;
    return r;
  endfunction

  function automatic row_t checked(op_e op, logic [15:0] v, logic [15:0] idx,
                                   logic [DistW-1:0] exp_dist, bit zn);
    row_t r;
    r = item(op, v, 1'b1);
    r.typed = 1'b1;
    r.res = '{idx, exp_dist, zn};
    return r;
  endfunction

  function automatic row_t cfg_row(reg_e sel, logic [7:0] val);
    row_t r;
    r = blank_row();
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic add_row(input row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    bit cand_end;
    int ncand;
    int cidx;
    int budget;
    op_e op;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = 1'b0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_cfg = 0;
    phase = -1;
    snd_idle = 0;
    rcv_idle = 0;
    ovr_en = 1'b0;
    elem_cnt = 0;
    cand_cnt = 0;
    clear_sums();
    best_dist = '0;
    best_pos = 0;
    best_ok = 1'b0;
    zero_seen = 1'b0;
    metric_r = 1'b0;
    length_r = 128;
    for (int i = 0; i < MaxLength; i++) begin
      query_mem[i] = '0;
      query_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(cfg_row(RegMetric, 8'd0));
    add_row(cfg_row(RegLength, 8'd1));
    add_row(item(OpQuery, 16'h7FFF, 0));
    add_row(item(OpCandidate, 16'h8000, 0));
    add_row(checked(OpCandidate, 16'h7FFF, 16'd1, '0, 0));
    add_row(item(OpQuery, 16'h0000, 0));
    add_row(checked(OpCandidate, 16'h0000, 16'd0, '0, 0));
    add_row(cfg_row(RegMetric, 8'd1));
    add_row(cfg_row(RegLength, 8'd2));
    add_row(item(OpQuery, 16'h0000, 0));
    add_row(item(OpQuery, 16'h0000, 0));
    add_row(item(OpCandidate, 16'h0001, 0));
    add_row(checked(OpCandidate, 16'h0001, 16'd0, DistMax, 1));
    add_row(item(OpQuery, 16'h0100, 0));
    add_row(item(OpQuery, 16'h0000, 0));
    add_row(item(OpCandidate, 16'h0100, 0));
    add_row(item(OpCandidate, 16'h0000, 0));
    add_row(item(OpCandidate, 16'hFF00, 0));
    add_row(checked(OpCandidate, 16'h0000, 16'd0, '0, 0));
    add_row(item(OpCandidate, 16'h0100, 0));
    add_row(item(OpQuery, 16'h0100, 0));
    add_row(item(OpCandidate, 16'h8000, 0));
    add_row(item(OpCandidate, 16'h7FFF, 1));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].reg_sel, rows[i].cfg_val);
      end else begin
        ovr_en = rows[i].typed;
        ovr_res = rows[i].res;
        send(rows[i].op, rows[i].val, rows[i].last, cand_end);
        ovr_en = 1'b0;
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(RegMetric, 8'(cfg_metric[ph]));
      write_reg(RegLength, 8'(cfg_length[ph]));
      phase = ph;
      if (ph < 3) begin
        snd_idle = 38;
        rcv_idle = 86;
      end else if (ph < 6) begin
        snd_idle = 86;
        rcv_idle = 38;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (ph == PressurePhase) snd_idle = 0;
      budget = (ph == PressurePhase) ? 300 : 200;
      budget += n_items;
      ncand = 0;
      cidx = 0;
      search_open = 1'b0;
      while (n_items < budget || search_open || elem_cnt != 0) begin
        if (!search_open) begin
          ncand = (ph == PressurePhase) ? 1 : $urandom_range(1, 4);
          cidx = 0;
          search_open = 1'b1;
        end
        if (!query_written[elem_cnt % MaxLength] || $urandom_range(99) < 4)
          op = OpQuery;
        else
          op = OpCandidate;
        send(op, rand_elem(), (cidx == ncand - 1) ? 1'b1 : 1'($urandom_range(9) == 0),
             cand_end);
        if (cand_end) begin
          if (s_axis_tlast) search_open = 1'b0;
          else cidx++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (nearest_q.size() != 0) errors++;
    $display("Ran %0d elements and %0d register writes; %0d search results compared,",
             n_items, n_cfg, n_results);
    $display("over both metrics, lengths 0 to 255, random stalls and a long output hold.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
